// ===== src/bisd_pkg.sv =====
`timescale 1ns / 1ps
package bisd_pkg;

  localparam int MAX_EXTRA_ARGS = 4096;
  localparam int EXTRA_W = $clog2(MAX_EXTRA_ARGS + 1);
  localparam int ARG_W = 13;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] ADDR_BIG_ENDIAN   = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_STRING_COUNT = 3'd4;

  localparam logic [1:0] EV_NOP   = 2'd0;
  localparam logic [1:0] EV_ARG   = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  localparam logic [2:0] ERR_OPCODE  = 3'd0;
  localparam logic [2:0] ERR_KIND    = 3'd1;
  localparam logic [2:0] ERR_INDEX   = 3'd2;
  localparam logic [2:0] ERR_BOOLEAN = 3'd3;
  localparam logic [2:0] ERR_COUNT   = 3'd4;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_IDENT  = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_INT    = 3'd3;
  localparam logic [2:0] KIND_FLOAT  = 3'd4;
  localparam logic [2:0] KIND_BOOL   = 3'd5;

  localparam logic [7:0] OP_CALL_A = 8'd23;
  localparam logic [7:0] OP_CALL_B = 8'd24;
  localparam logic [7:0] OP_CALL_C = 8'd25;
  localparam logic [7:0] OP_LAST   = 8'd35;

  typedef enum logic [3:0] {
    PH_OPCODE = 4'b0001,
    PH_KIND   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       known;
    logic [2:0] nargs;
  } op_info_t;

  typedef struct packed {
    logic       clear;
    logic [7:0] data;
    logic       op_known;
    logic [2:0] op_nargs;
    logic       kind_bad;
  } q_entry_t;

  function automatic op_info_t op_class(input logic [7:0] op);
    op_info_t r;
    r.known = (op <= OP_LAST);
    if (op == 8'd0) r.nargs = 3'd0;
    else if (op == 8'd20 || op == 8'd26) r.nargs = 3'd1;
    else if ((op >= 8'd10 && op <= 8'd14) || op == 8'd21 || op == 8'd22 ||
             op == 8'd30 || op == 8'd31 || op == OP_CALL_B) r.nargs = 3'd2;
    else if (op == 8'd34 || op == OP_LAST) r.nargs = 3'd4;
    else r.nargs = 3'd3;
    return r;
  endfunction

  function automatic logic is_call(input logic [7:0] op);
    return op == OP_CALL_A || op == OP_CALL_B || op == OP_CALL_C;
  endfunction

endpackage

// ===== src/bisd_if.sv =====
`timescale 1ns / 1ps
interface bisd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       clear;
  modport source(output valid, in_byte, clear, input ready);
  modport sink(input valid, in_byte, clear, output ready);
endinterface

interface bisd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  opcode;
  logic [12:0] arg_index;
  logic [2:0]  value_kind;
  logic [31:0] value_bits;
  logic        last_arg;
  logic [2:0]  error_code;
  modport source(output valid, event_res, opcode, arg_index, value_kind, value_bits,
                 last_arg, error_code, input ready);
  modport sink(input valid, event_res, opcode, arg_index, value_kind, value_bits,
               last_arg, error_code, output ready);
endinterface

// ===== src/bisd_front.sv =====
`timescale 1ns / 1ps
module bisd_front import bisd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  bisd_in_if.sink        in_if,
  output logic           q_valid,
  output q_entry_t       q_data,
  input  logic           q_pop
);

  q_entry_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                  push;
  op_info_t              info;
  q_entry_t              new_entry;

  assign in_if.ready = (cnt_r < QCNT_W'(QDEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_data      = entry_r[rd_ptr_r];

  always_comb begin
    info               = op_class(in_if.in_byte);
    new_entry.clear    = in_if.clear;
    new_entry.data     = in_if.in_byte;
    new_entry.op_known = info.known;
    new_entry.op_nargs = info.nargs;
    new_entry.kind_bad = (in_if.in_byte > 8'(KIND_BOOL));
  end

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'((32'(wr_ptr_r) + 1) % QDEPTH) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? QPTR_W'((32'(rd_ptr_r) + 1) % QDEPTH) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

// ===== src/bisd_back.sv =====
`timescale 1ns / 1ps
module bisd_back import bisd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           big_endian,
  input  logic [15:0]    string_count,
  input  logic           q_valid,
  input  q_entry_t       q_data,
  output logic           q_pop,
  bisd_out_if.source     out_if
);

  phase_t              phase_r, phase_nxt;
  logic [7:0]          held_op_r, held_op_nxt;
  logic [2:0]          held_kind_r, held_kind_nxt;
  logic [1:0]          byte_pos_r, byte_pos_nxt;
  logic [31:0]         asm_r, asm_nxt;
  logic [ARG_W-1:0]    arg_pos_r, arg_pos_nxt;
  logic [2:0]          fixed_r, fixed_nxt;
  logic [EXTRA_W-1:0]  extra_r, extra_nxt;
  logic                rc_r, rc_nxt;

  logic                out_valid_r;
  logic [1:0]          ev_r;
  logic [7:0]          op_r;
  logic [ARG_W-1:0]    idx_r;
  logic [2:0]          kind_r;
  logic [31:0]         bits_r;
  logic                last_r;
  logic [2:0]          err_r;

  logic                can_go;
  logic                res_v, res_last;
  logic [1:0]          res_ev;
  logic [7:0]          res_op;
  logic [ARG_W-1:0]    res_idx;
  logic [2:0]          res_kind, res_err;
  logic [31:0]         res_bits;
  logic                fin;
  logic [2:0]          fin_kind;
  logic [31:0]         fin_bits;
  logic [31:0]         asm_new;
  logic                data_done;
  logic [2:0]          fixed_dec;
  logic [EXTRA_W-1:0]  extra_dec;

  assign can_go = !out_valid_r || out_if.ready;
  assign q_pop  = q_valid && can_go;

  always_comb begin
    phase_nxt     = phase_r;
    held_op_nxt   = held_op_r;
    held_kind_nxt = held_kind_r;
    byte_pos_nxt  = byte_pos_r;
    asm_nxt       = asm_r;
    arg_pos_nxt   = arg_pos_r;
    fixed_nxt     = fixed_r;
    extra_nxt     = extra_r;
    rc_nxt        = rc_r;
    res_v         = 1'b0;
    res_ev        = EV_ARG;
    res_op        = held_op_r;
    res_idx       = arg_pos_r;
    res_kind      = KIND_NONE;
    res_bits      = '0;
    res_last      = 1'b0;
    res_err       = ERR_OPCODE;
    fin           = 1'b0;
    fin_kind      = KIND_NONE;
    fin_bits      = '0;
    fixed_dec     = fixed_r - 3'd1;
    extra_dec     = (extra_r != '0) ? extra_r - EXTRA_W'(1) : extra_r;

    if (big_endian) asm_new = {asm_r[23:0], q_data.data};
    else asm_new = asm_r | ({24'd0, q_data.data} << {byte_pos_r, 3'b000});
    case (held_kind_r)
      KIND_IDENT, KIND_STRING: data_done = (byte_pos_r == 2'd1);
      KIND_INT, KIND_FLOAT:    data_done = (byte_pos_r == 2'd3);
      default:                 data_done = 1'b1;
    endcase

    if (q_pop) begin
      if (q_data.clear) begin
        phase_nxt     = PH_OPCODE;
        held_op_nxt   = '0;
        held_kind_nxt = '0;
        byte_pos_nxt  = '0;
        asm_nxt       = '0;
        arg_pos_nxt   = '0;
        fixed_nxt     = '0;
        extra_nxt     = '0;
        rc_nxt        = 1'b0;
      end else begin
        case (phase_r)
          PH_OPCODE: begin
            held_op_nxt = q_data.data;
            arg_pos_nxt = '0;
            rc_nxt      = 1'b0;
            extra_nxt   = '0;
            res_op      = q_data.data;
            res_idx     = '0;
            if (!q_data.op_known) begin
              res_v     = 1'b1;
              res_ev    = EV_ERROR;
              res_err   = ERR_OPCODE;
              phase_nxt = PH_ERROR;
            end else if (q_data.op_nargs == 3'd0) begin
              res_v    = 1'b1;
              res_ev   = EV_NOP;
              res_last = 1'b1;
            end else begin
              fixed_nxt = q_data.op_nargs;
              phase_nxt = PH_KIND;
            end
          end
          PH_KIND: begin
            if (q_data.kind_bad) begin
              res_v     = 1'b1;
              res_ev    = EV_ERROR;
              res_err   = ERR_KIND;
              phase_nxt = PH_ERROR;
            end else if (q_data.data == 8'd0) begin
              fin = 1'b1;
            end else begin
              held_kind_nxt = q_data.data[2:0];
              byte_pos_nxt  = '0;
              asm_nxt       = '0;
              phase_nxt     = PH_DATA;
            end
          end
          PH_DATA: begin
            asm_nxt = asm_new;
            if (!data_done) begin
              byte_pos_nxt = byte_pos_r + 2'd1;
            end else begin
              byte_pos_nxt = '0;
              if (held_kind_r == KIND_BOOL && asm_new[31:1] != '0) begin
                res_v     = 1'b1;
                res_ev    = EV_ERROR;
                res_err   = ERR_BOOLEAN;
                phase_nxt = PH_ERROR;
              end else if ((held_kind_r == KIND_IDENT || held_kind_r == KIND_STRING) &&
                           asm_new >= {16'd0, string_count}) begin
                res_v     = 1'b1;
                res_ev    = EV_ERROR;
                res_err   = ERR_INDEX;
                phase_nxt = PH_ERROR;
              end else begin
                fin      = 1'b1;
                fin_kind = held_kind_r;
                fin_bits = asm_new;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (fin) begin
      res_v = 1'b1;
      if (rc_r && (fin_kind != KIND_INT || fin_bits[31] ||
                   fin_bits > 32'(MAX_EXTRA_ARGS))) begin
        res_ev    = EV_ERROR;
        res_err   = ERR_COUNT;
        phase_nxt = PH_ERROR;
      end else begin
        phase_nxt = PH_KIND;
        if (rc_r) begin
          rc_nxt    = 1'b0;
          extra_nxt = fin_bits[EXTRA_W-1:0];
          res_last  = (fin_bits[EXTRA_W-1:0] == '0);
        end else if (fixed_r != 3'd0) begin
          fixed_nxt = fixed_dec;
          if (fixed_dec == 3'd0) begin
            if (is_call(held_op_r)) rc_nxt = 1'b1;
            else res_last = 1'b1;
          end
        end else begin
          extra_nxt = extra_dec;
          res_last  = (extra_dec == '0);
        end
        res_kind    = fin_kind;
        res_bits    = fin_bits;
        arg_pos_nxt = arg_pos_r + ARG_W'(1);
        if (res_last) phase_nxt = PH_OPCODE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      held_op_r   <= '0;
      held_kind_r <= '0;
      byte_pos_r  <= '0;
      asm_r       <= '0;
      arg_pos_r   <= '0;
      fixed_r     <= '0;
      extra_r     <= '0;
      rc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      held_op_r   <= held_op_nxt;
      held_kind_r <= held_kind_nxt;
      byte_pos_r  <= byte_pos_nxt;
      asm_r       <= asm_nxt;
      arg_pos_r   <= arg_pos_nxt;
      fixed_r     <= fixed_nxt;
      extra_r     <= extra_nxt;
      rc_r        <= rc_nxt;
      if (can_go) out_valid_r <= q_pop && res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_v) begin
      ev_r   <= res_ev;
      op_r   <= res_op;
      idx_r  <= res_idx;
      kind_r <= res_kind;
      bits_r <= res_bits;
      last_r <= res_last;
      err_r  <= (res_ev == EV_ERROR) ? res_err : ERR_OPCODE;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.event_res  = ev_r;
  assign out_if.opcode     = op_r;
  assign out_if.arg_index  = idx_r;
  assign out_if.value_kind = kind_r;
  assign out_if.value_bits = bits_r;
  assign out_if.last_arg   = last_r;
  assign out_if.error_code = err_r;

endmodule

// ===== src/bytecode_instruction_stream_decoder.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals                                              Transfer
// in_if     in   in_byte[7:0] clear                                   valid & ready
// out_if    out  event_res opcode arg_index value_kind value_bits     valid & ready
//                last_arg error_code
// cfg (APB) in   psel penable pwrite paddr[2:0] pwdata prdata pready  psel & penable
//
// One byte per cycle sustained while out_if is not stalled; a byte's result passes
// through a queue entry, then the output register, before it is valid.
// rst_n is synchronous, active low; big_endian resets to 1, string_count to 0.
// A stalled output holds its register; a two-entry queue absorbs the next bytes,
// then in_if.ready drops.
module bytecode_instruction_stream_decoder import bisd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bisd_in_if.sink            in_if,
  bisd_out_if.source         out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic        big_endian_r, big_endian_nxt;
  logic [15:0] string_count_r, string_count_nxt;
  logic        cfg_wr;
  logic        q_valid, q_pop;
  q_entry_t    q_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    big_endian_nxt   = big_endian_r;
    string_count_nxt = string_count_r;
    if (cfg_wr && paddr == ADDR_BIG_ENDIAN) big_endian_nxt = pwdata[0];
    if (cfg_wr && paddr == ADDR_STRING_COUNT) string_count_nxt = pwdata[15:0];
    case (paddr)
      ADDR_BIG_ENDIAN:   prdata = {31'd0, big_endian_r};
      ADDR_STRING_COUNT: prdata = {16'd0, string_count_r};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r   <= 1'b1;
      string_count_r <= '0;
    end else begin
      big_endian_r   <= big_endian_nxt;
      string_count_r <= string_count_nxt;
    end
  end

  bisd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  bisd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .big_endian   (big_endian_r),
    .string_count (string_count_r),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_if       (out_if)
  );

endmodule

// ===== src/bisd_checker.sv =====
`timescale 1ns / 1ps
module bisd_checker import bisd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_res,
  input logic [12:0] arg_index,
  input logic [2:0]  value_kind,
  input logic [31:0] value_bits,
  input logic        last_arg,
  input logic [2:0]  error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(value_bits) && $stable(event_res))
    else $error("result dropped or changed while stalled");

  a_nop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_NOP |->
      last_arg && arg_index == '0 && value_kind == KIND_NONE && value_bits == '0)
    else $error("malformed nop event");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_ERROR |->
      !last_arg && value_kind == KIND_NONE && value_bits == '0)
    else $error("malformed error event");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != EV_ERROR |-> error_code == ERR_OPCODE)
    else $error("error code on a non-error event");

  a_bool_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_ARG && value_kind == KIND_BOOL |-> value_bits[31:1] == '0)
    else $error("boolean value out of range");

endmodule

bind bytecode_instruction_stream_decoder bisd_checker u_bisd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .event_res  (out_if.event_res),
  .arg_index  (out_if.arg_index),
  .value_kind (out_if.value_kind),
  .value_bits (out_if.value_bits),
  .last_arg   (out_if.last_arg),
  .error_code (out_if.error_code)
);
